// ===== hdl/nzia_pkg.sv =====
// ----------------------------------------------------------------------------
// nzia_pkg
// types, constants and codes shared by the nested zone alarm modules
// ----------------------------------------------------------------------------
package nzia_pkg;

  localparam int MAX_ZONES  = 10;
  localparam int COUNT_BITS = 16;

  localparam int COORD_W   = 16;
  localparam int STEP_W    = 12;
  localparam int THR_W     = 16;
  localparam int ZLVL_W    = 4;
  localparam int FLAGS_W   = 10;
  localparam int CLEARS_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // level counts run 0..MAX_ZONES
  localparam int LVL_W = $clog2(MAX_ZONES + 1);
  localparam int IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int IDX1  = (MAX_ZONES > 1) ? 1 : 0;

  // half size of a zone and the signed bound width
  localparam int HX_W  = STEP_W + LVL_W;
  localparam int BND_W = ((HX_W > COORD_W) ? HX_W : COORD_W) + 2;

  typedef logic [MAX_ZONES-1:0] zone_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE_LEVELS = 3'd0,
    REG_COUNT_THR   = 3'd1,
    REG_STEP_X      = 3'd2,
    REG_STEP_Y      = 3'd3,
    REG_FRONT_X     = 3'd4,
    REG_FRONT_Y     = 3'd5,
    REG_REAR_X      = 3'd6,
    REG_REAR_Y      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PERIOD_SLOW   = 2'd0,
    PERIOD_MEDIUM = 2'd1,
    PERIOD_FAST   = 2'd2
  } period_e;

  typedef struct packed {
    logic [ZLVL_W-1:0]         zone_levels;
    logic [THR_W-1:0]          count_threshold;
    logic [STEP_W-1:0]         step_x_mm;
    logic [STEP_W-1:0]         step_y_mm;
    logic signed [COORD_W-1:0] front_x_mm;
    logic signed [COORD_W-1:0] front_y_mm;
    logic signed [COORD_W-1:0] rear_x_mm;
    logic signed [COORD_W-1:0] rear_y_mm;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x_mm;
    logic signed [COORD_W-1:0] point_y_mm;
    logic                      has_point;
    logic                      frame_end;
  } point_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]  zone_flags;
    logic                play_now;
    logic                alarm_on;
    logic [1:0]          alarm_period;
    logic [CLEARS_W-1:0] clear_zones;
  } alert_t;

  // what travels from one cell to the next
  typedef struct packed {
    logic             valid;
    logic             frame_end;
    zone_vec_t        hit;      // bit 0 belongs to the receiving cell
    logic [LVL_W-1:0] levels;   // zones in use for this beat
    logic [LVL_W-1:0] lv_rem;   // zones in use from the receiving cell on
    logic [LVL_W-1:0] clear;    // zones in use that did not exceed the threshold
    zone_vec_t        flags;    // shifted in from the top
    zone_vec_t        rise;     // flag rose against last frame
  } beat_t;

endpackage

// ===== hdl/nested_zone_intrusion_alarm.sv =====
// ----------------------------------------------------------------------------
// nested_zone_intrusion_alarm
// counts scan points per nested zone and raises alarm results at frame end
// ----------------------------------------------------------------------------
// a frame-end beat passes the probe register, the zone cell registers and the alert register before it shows on alert
// throughput: one point beat per cycle, set by the zone cell chain advancing
//   together; the chain holds only while a finished alert waits and the next
//   frame end reaches the chain's end
// reset: synchronous; config takes its default values, counts, last flags,
//   last clear count and alarm period clear, the chain empties
// ----------------------------------------------------------------------------
module nested_zone_intrusion_alarm (
  input  logic                                clk,
  input  logic                                rst,
  // point beats
  input  logic                                point_valid,
  output logic                                point_ready,
  input  nzia_pkg::point_t                    point,
  // alert beats
  output logic                                alert_valid,
  input  logic                                alert_ready,
  output nzia_pkg::alert_t                    alert,
  // config writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nzia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nzia_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import nzia_pkg::*;

  cfg_t             cfg;
  logic             adv;
  beat_t            chain [0:MAX_ZONES];
  beat_t            tail;

  // tail state
  logic [LVL_W-1:0] last_clear;
  period_e          period;
  period_e          period_next;

  logic             tail_done;
  logic             levels_nz;
  logic [IDX_W-1:0] top_idx;
  logic             top_flag;
  logic             clear_rise;
  logic             rise0;
  logic             rise1;
  alert_t           alert_next;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_levels     <= ZLVL_W'(2);
      cfg.count_threshold <= THR_W'(50);
      cfg.step_x_mm       <= STEP_W'(3000);
      cfg.step_y_mm       <= STEP_W'(1000);
      cfg.front_x_mm      <= '0;
      cfg.front_y_mm      <= '0;
      cfg.rear_x_mm       <= '0;
      cfg.rear_y_mm       <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_ZONE_LEVELS: cfg.zone_levels     <= cfg_data[ZLVL_W-1:0];
        REG_COUNT_THR:   cfg.count_threshold <= cfg_data[THR_W-1:0];
        REG_STEP_X:      cfg.step_x_mm       <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:      cfg.step_y_mm       <= cfg_data[STEP_W-1:0];
        REG_FRONT_X:     cfg.front_x_mm      <= $signed(cfg_data[COORD_W-1:0]);
        REG_FRONT_Y:     cfg.front_y_mm      <= $signed(cfg_data[COORD_W-1:0]);
        REG_REAR_X:      cfg.rear_x_mm       <= $signed(cfg_data[COORD_W-1:0]);
        REG_REAR_Y:      cfg.rear_y_mm       <= $signed(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // whole chain moves as one; it only holds when a frame end at the chain's
  // end has nowhere to go
  assign tail        = chain[MAX_ZONES];
  assign tail_done   = tail.valid && tail.frame_end;
  assign adv         = !(tail_done && alert_valid && !alert_ready);
  assign point_ready = adv;

  // head: rectangle tests for all zones
  nzia_probe u_probe (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .take  (point_valid),
    .point (point),
    .cfg   (cfg),
    .beat  (chain[0])
  );

  // one cell per zone, zone 0 first
  for (genvar j = 0; j < MAX_ZONES; j++) begin : g_cell
    nzia_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .thr  (cfg.count_threshold),
      .up   (chain[j]),
      .down (chain[j+1])
    );
  end

  // ---------------------------------------------------------------- frame end
  // outermost zone in use is visited first and is the only one that can see
  // a rise in the clear count
  assign levels_nz  = (tail.levels != '0);
  assign top_idx    = IDX_W'(tail.levels - LVL_W'(1));
  assign top_flag   = levels_nz && tail.flags[top_idx];
  assign clear_rise = top_flag && (last_clear < tail.clear);

  assign rise0 = tail.rise[0] || (clear_rise && (tail.levels == LVL_W'(1)));
  assign rise1 = (MAX_ZONES > 1) &&
                 (tail.rise[IDX1] || (clear_rise && (tail.levels == LVL_W'(2))));

  // lowest zone with a rise has the last word on the period
  always_comb begin
    period_next = period;
    if (rise0) begin
      period_next = PERIOD_FAST;
    end else if (rise1) begin
      period_next = PERIOD_MEDIUM;
    end
  end

  always_comb begin
    alert_next.zone_flags   = FLAGS_W'(tail.flags);
    alert_next.play_now     = (|tail.rise) || clear_rise;
    alert_next.alarm_on     = (tail.clear != tail.levels);
    alert_next.alarm_period = period_next;
    alert_next.clear_zones  = CLEARS_W'(tail.clear);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clear <= '0;
      period     <= PERIOD_SLOW;
    end else if (adv && tail_done) begin
      period <= period_next;
      if (levels_nz) begin
        last_clear <= tail.clear;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_valid <= 1'b0;
    end else if (adv && tail_done) begin
      alert_valid <= 1'b1;
    end else if (alert_ready) begin
      alert_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_done) begin
      alert <= alert_next;
    end
  end

endmodule

// ===== hdl/nzia_probe.sv =====
// ----------------------------------------------------------------------------
// nzia_probe
// head stage: tests a point against every zone rectangle at once
// ----------------------------------------------------------------------------
module nzia_probe (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            take,
  input  nzia_pkg::point_t point,
  input  nzia_pkg::cfg_t   cfg,
  output nzia_pkg::beat_t  beat
);
  import nzia_pkg::*;

  logic [LVL_W-1:0]        levels;
  zone_vec_t               hit;
  logic signed [BND_W-1:0] px;
  logic signed [BND_W-1:0] py;

  assign levels = (32'(cfg.zone_levels) > MAX_ZONES) ? LVL_W'(MAX_ZONES)
                                                     : LVL_W'(cfg.zone_levels);
  assign px = BND_W'(point.point_x_mm);
  assign py = BND_W'(point.point_y_mm);

  for (genvar j = 0; j < MAX_ZONES; j++) begin : g_zone
    localparam logic [HX_W-1:0] MULT = HX_W'(j + 1);
    logic [HX_W-1:0]         hx;
    logic [HX_W-1:0]         hy;
    logic signed [BND_W-1:0] hi_x;
    logic signed [BND_W-1:0] lo_x;
    logic signed [BND_W-1:0] hi_y;
    logic signed [BND_W-1:0] lo_y;

    assign hx   = HX_W'(cfg.step_x_mm) * MULT;
    assign hy   = HX_W'(cfg.step_y_mm) * MULT;
    assign hi_x = BND_W'(cfg.front_x_mm) + $signed({{(BND_W-HX_W){1'b0}}, hx});
    assign lo_x = BND_W'(cfg.rear_x_mm)  - $signed({{(BND_W-HX_W){1'b0}}, hx});
    assign hi_y = BND_W'(cfg.front_y_mm) + $signed({{(BND_W-HX_W){1'b0}}, hy});
    assign lo_y = BND_W'(cfg.rear_y_mm)  - $signed({{(BND_W-HX_W){1'b0}}, hy});

    assign hit[j] = point.has_point && (32'(levels) > j) &&
                    (px < hi_x) && (px > lo_x) && (py < hi_y) && (py > lo_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (adv) begin
      beat.valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat.frame_end <= point.frame_end;
      beat.hit       <= hit;
      beat.levels    <= levels;
      beat.lv_rem    <= levels;
      beat.clear     <= '0;
      beat.flags     <= '0;
      beat.rise      <= '0;
    end
  end

endmodule

// ===== hdl/nzia_cell.sv =====
// ----------------------------------------------------------------------------
// nzia_cell
// one zone: saturating point count, last flag, frame-end summary
// ----------------------------------------------------------------------------
module nzia_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [nzia_pkg::THR_W-1:0]    thr,
  input  nzia_pkg::beat_t               up,
  output nzia_pkg::beat_t               down
);
  import nzia_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  last_flag;
  logic                  in_use;
  logic                  flag;
  logic                  frame_done;
  beat_t                 beat_next;

  assign in_use     = (up.lv_rem != '0);
  assign frame_done = up.valid && up.frame_end;

  // own point counts before the frame closes
  assign count_next = (up.valid && up.hit[0] && (count != '1))
                    ? count + COUNT_BITS'(1) : count;
  assign flag = in_use && (32'(count_next) > 32'(thr));

  always_comb begin
    beat_next        = up;
    beat_next.hit    = up.hit >> 1;
    beat_next.lv_rem = in_use ? up.lv_rem - LVL_W'(1) : '0;
    beat_next.clear  = up.clear + LVL_W'(in_use && !flag);
    beat_next.flags  = up.flags >> 1;
    beat_next.rise   = up.rise >> 1;
    beat_next.flags[MAX_ZONES-1] = flag;
    beat_next.rise[MAX_ZONES-1]  = flag && !last_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_flag <= 1'b0;
    end else if (adv && up.valid) begin
      count <= up.frame_end ? '0 : count_next;
      if (frame_done && in_use) begin
        last_flag <= flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (adv) begin
      down.valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      down.frame_end <= beat_next.frame_end;
      down.hit       <= beat_next.hit;
      down.levels    <= beat_next.levels;
      down.lv_rem    <= beat_next.lv_rem;
      down.clear     <= beat_next.clear;
      down.flags     <= beat_next.flags;
      down.rise      <= beat_next.rise;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nested zone intrusion alarm testbench
// drives point beats and register writes into the zone counter and checks
// every alert beat against an in-bench model of the zone logic or a hand-typed alert
// ----------------------------------------------------------------------------
module testbench;
  import nzia_pkg::*;

  // stimulus volume and pacing
  localparam int ITEM_GOAL     = 1200;
  localparam int CALM_ITEMS    = 200;            // tail of the run with no idling
  localparam int SETTLE_CYCLES = MAX_ZONES + 4;  // alert latency plus margin
  localparam int STALL_LIMIT   = 4000;           // cycles with no beat at all

  // one row of the directed table: either a register write or a point beat,
  // optionally with the alert typed in by hand
  typedef struct packed {
    bit        is_cfg;
    cfg_reg_e  ridx;
    logic [CFG_DAT_W-1:0] rval;
    point_t    pt;
    bit        typed;
    alert_t    want;
  } stim_row_t;

  // dut ports, all inputs known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  point_t point = '0;
  logic point_ready;
  logic alert_valid;
  logic alert_ready = 1'b0;
  alert_t alert;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // model copy of the registers
  int lvl_r, thr_r, stx_r, sty_r, fx_r, fy_r, rx_r, ry_r;
  // model copy of the zone state
  logic [COUNT_BITS-1:0] zcnt [MAX_ZONES];
  bit last_flag [MAX_ZONES];
  int last_clr;
  period_e period_r;

  alert_t alert_due [$];    // alerts still owed by the dut, oldest first
  stim_row_t dir_tab [$];
  int bad_beats = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;          // no idling on either side once set

  nested_zone_intrusion_alarm uut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point       (point),
    .alert_valid (alert_valid),
    .alert_ready (alert_ready),
    .alert       (alert),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // zone model
  // ------------------------------------------------------------------------

  // register write as the dut sees it, narrow fields keep their low bits
  function automatic void set_zone_reg(cfg_reg_e r, logic [CFG_DAT_W-1:0] d);
    case (r)
      REG_ZONE_LEVELS: lvl_r = int'(d[ZLVL_W-1:0]);
      REG_COUNT_THR:   thr_r = int'(d[THR_W-1:0]);
      REG_STEP_X:      stx_r = int'(d[STEP_W-1:0]);
      REG_STEP_Y:      sty_r = int'(d[STEP_W-1:0]);
      REG_FRONT_X:     fx_r  = int'($signed(d));
      REG_FRONT_Y:     fy_r  = int'($signed(d));
      REG_REAR_X:      rx_r  = int'($signed(d));
      default:         ry_r  = int'($signed(d));
    endcase
  endfunction

  // count the point into every zone in use that it sits strictly inside; on
  // frame end build the alert and clear the counts. returns 1 when an alert is due
  function automatic bit advance_zones(point_t p, output alert_t res);
    int lv, hx, hy, px, py, nclr, j;
    bit play, f;
    res = '0;
    lv = (lvl_r > MAX_ZONES) ? MAX_ZONES : lvl_r;
    if (p.has_point) begin
      px = int'($signed(p.point_x_mm));
      py = int'($signed(p.point_y_mm));
      for (j = 0; j < lv; j++) begin
        hx = stx_r * (j + 1);
        hy = sty_r * (j + 1);
        if (px < fx_r + hx && px > rx_r - hx && py < fy_r + hy && py > ry_r - hy)
          if (zcnt[j] != '1) zcnt[j]++;
      end
    end
    if (!p.frame_end) return 1'b0;

    nclr = 0;
    for (j = 0; j < lv; j++)
      if (!(int'(zcnt[j]) > thr_r)) nclr++;

    // outermost zone first, so only it can see the clear-count rise
    play = 1'b0;
    for (j = lv - 1; j >= 0; j--) begin
      f = int'(zcnt[j]) > thr_r;
      if (f) begin
        res.zone_flags[j] = 1'b1;
        if (!last_flag[j] || last_clr < nclr) begin
          if (j == 0) period_r = PERIOD_FAST;
          else if (j == 1) period_r = PERIOD_MEDIUM;
          play = 1'b1;
        end
      end
      last_flag[j] = f;
      last_clr = nclr;
    end
    for (j = 0; j < MAX_ZONES; j++) zcnt[j] = '0;

    res.play_now     = play;
    res.alarm_on     = (nclr != lv);
    res.alarm_period = period_r;
    res.clear_zones  = nclr[CLEARS_W-1:0];
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic stim_row_t cfg_row(cfg_reg_e r, logic [CFG_DAT_W-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.ridx = r;
    s.rval = v;
    return s;
  endfunction

  function automatic stim_row_t pt_row(int x, int y, bit hp, bit fe,
                                       bit typed = 1'b0, alert_t want = '0);
    stim_row_t s;
    s = '0;
    s.pt.point_x_mm = x[COORD_W-1:0];
    s.pt.point_y_mm = y[COORD_W-1:0];
    s.pt.has_point = hp;
    s.pt.frame_end = fe;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic int clip16(int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  // coordinate near the zone stack: mostly inside the outer zone span, some
  // right on a zone edge, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi, int stp);
    int lv, k, a, b, v;
    lv = (lvl_r > MAX_ZONES) ? MAX_ZONES : ((lvl_r < 1) ? 1 : lvl_r);
    case ($urandom_range(0, 7))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1, 2: begin
        k = $urandom_range(1, lv);
        v = ($urandom_range(0, 1) ? hi + stp * k : lo - stp * k)
            + int'($urandom_range(0, 2)) - 1;
      end
      default: begin
        a = clip16(lo - stp * lv - 50);
        b = clip16(hi + stp * lv + 50);
        v = (a < b) ? a + int'($urandom_range(0, b - a))
                    : int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    return COORD_W'(clip16(v));
  endfunction

  // register value for a random phase; one in eight is any value at all
  function automatic logic [CFG_DAT_W-1:0] pick_reg(cfg_reg_e r);
    logic [CFG_DAT_W-1:0] v;
    bit wild;
    v = CFG_DAT_W'($urandom);
    wild = ($urandom_range(0, 7) == 0);
    if (!wild) begin
      case (r)
        REG_ZONE_LEVELS:        v[ZLVL_W-1:0] = ZLVL_W'($urandom_range(1, MAX_ZONES));
        REG_COUNT_THR:          v = CFG_DAT_W'($urandom_range(0, 10));
        REG_STEP_X, REG_STEP_Y: v[STEP_W-1:0] = STEP_W'($urandom_range(50, 1500));
        REG_FRONT_X, REG_FRONT_Y:
          v = 16'(int'($urandom_range(0, 6000)) - 2000);
        default:                v = 16'(2000 - int'($urandom_range(0, 6000)));
      endcase
    end
    return v;
  endfunction

  // one point beat; holds valid until accepted, then books the alert it owes
  task automatic push_point(point_t p, bit typed = 1'b0, alert_t want = '0);
    alert_t got;
    point_valid <= 1'b1;
    point <= p;
    do @(posedge clk); while (!point_ready);
    if (advance_zones(p, got)) alert_due.insert(alert_due.size(), typed ? want : got);
  endtask

  // one register write beat; valid stays up for back-to-back writes
  task automatic write_reg(cfg_reg_e r, logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    set_zone_reg(r, d);
  endtask

  // sender gap burst, skipped in the calm tail
  task automatic random_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait for every owed alert, then idle for SETTLE_CYCLES so the cell chain empties
  task automatic settle();
    point_valid <= 1'b0;
    while (alert_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_bad(string what);
    bad_beats++;
    if (bad_beats <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // ------------------------------------------------------------------------
  // alert side: random stall bursts and the check of each beat
  // ------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : alert_side
    alert_t want;
    if (rst) begin
      alert_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (alert_valid && alert_ready) begin
        if (alert_due.size() == 0) begin
          flag_bad($sformatf("alert beat with nothing owed: flags=%03h", alert.zone_flags));
        end else begin
          want = alert_due.pop_front();
          if (alert.zone_flags !== want.zone_flags || alert.play_now !== want.play_now ||
              alert.alarm_on !== want.alarm_on ||
              alert.alarm_period !== want.alarm_period ||
              alert.clear_zones !== want.clear_zones)
            flag_bad($sformatf({"alert mismatch: expected flags=%03h play=%0b on=%0b ",
                                "period=%0d clear=%0d, got flags=%03h play=%0b on=%0b ",
                                "period=%0d clear=%0d"},
                               want.zone_flags, want.play_now, want.alarm_on,
                               want.alarm_period, want.clear_zones,
                               alert.zone_flags, alert.play_now, alert.alarm_on,
                               alert.alarm_period, alert.clear_zones));
        end
      end
      // one nonblocking update of ready per cycle
      if (stall_left > 0) begin
        stall_left--;
        alert_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        alert_ready <= 1'b0;
      end else begin
        alert_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any beat on any channel ends the run
  always @(posedge clk) begin
    if (rst || (point_valid && point_ready) || (alert_valid && alert_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    point_t p;
    bit in_cfg;
    int items, phase_end, n, k;

    // model matches the dut's reset values
    lvl_r = 2; thr_r = 50; stx_r = 3000; sty_r = 1000;
    fx_r = 0; fy_r = 0; rx_r = 0; ry_r = 0;
    for (k = 0; k < MAX_ZONES; k++) begin
      zcnt[k] = '0;
      last_flag[k] = 1'b0;
    end
    last_clr = 0;
    period_r = PERIOD_SLOW;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows: register writes happen only with the block drained
    dir_tab = '{
      // frame end straight after reset: two clear zones, slow period
      pt_row(0, 0, 1'b0, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0, PERIOD_SLOW, 4'd2}),
      // no zone in use
      cfg_row(REG_ZONE_LEVELS, 16'd0),
      pt_row(0, 0, 1'b1, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0, PERIOD_SLOW, 4'd0}),
      // all zones, steps of 3276, threshold at its top
      cfg_row(REG_ZONE_LEVELS, 16'd10),
      cfg_row(REG_COUNT_THR, 16'hFFFF),
      cfg_row(REG_STEP_X, 16'd3276),
      cfg_row(REG_STEP_Y, 16'd3276),
      pt_row(0, 0, 1'b1, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0, PERIOD_SLOW, 4'd10}),
      // threshold zero: one point trips every zone it is in
      cfg_row(REG_COUNT_THR, 16'd0),
      pt_row(32767, 32767, 1'b1, 1'b0),
      pt_row(-32768, -32768, 1'b1, 1'b0),
      pt_row(100, -100, 1'b1, 1'b1),
      pt_row(0, 0, 1'b0, 1'b1),
      // levels above the zone count saturate, origins at their extremes
      cfg_row(REG_ZONE_LEVELS, 16'hFFFF),
      cfg_row(REG_FRONT_X, 16'h7FFF),
      cfg_row(REG_REAR_X, 16'h8000),
      cfg_row(REG_FRONT_Y, 16'h7FFF),
      cfg_row(REG_REAR_Y, 16'h8000),
      pt_row(32767, 0, 1'b1, 1'b0),
      pt_row(-32768, -32768, 1'b1, 1'b1),
      // zero steps, one zone
      cfg_row(REG_STEP_X, 16'd0),
      cfg_row(REG_STEP_Y, 16'd0),
      cfg_row(REG_ZONE_LEVELS, 16'd1),
      pt_row(0, 0, 1'b1, 1'b0),
      pt_row(1, 1, 1'b0, 1'b0),
      pt_row(-1, 32766, 1'b1, 1'b1),
      pt_row(5, 5, 1'b1, 1'b1)
    };

    in_cfg = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        write_reg(dir_tab[i].ridx, dir_tab[i].rval);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        push_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].want);
        random_gap();
      end
    end

    // random phases: fresh registers each phase, then whole frames
    items = 0;
    while (items < ITEM_GOAL) begin
      settle();
      for (k = 0; k < 8; k++) write_reg(cfg_reg_e'(k), pick_reg(cfg_reg_e'(k)));
      cfg_valid <= 1'b0;
      phase_end = items + $urandom_range(60, 150);
      while (items < phase_end && items < ITEM_GOAL) begin
        calm = (items >= ITEM_GOAL - CALM_ITEMS);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 80) : $urandom_range(0, 20);
        for (k = 0; k <= n; k++) begin
          p.point_x_mm = pick_coord(rx_r, fx_r, stx_r);
          p.point_y_mm = pick_coord(ry_r, fy_r, sty_r);
          p.has_point = ($urandom_range(0, 9) != 0);
          p.frame_end = (k == n);
          push_point(p);
          if (p.has_point || p.frame_end) items++;
          random_gap();
        end
      end
    end

    // drain and give a stray beat time to show up
    point_valid <= 1'b0;
    while (alert_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (alert_due.size() != 0) flag_bad("alerts still owed at the end");

    if (bad_beats == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
